// File: rtl/ecal_pkg.sv
package ecal_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_CHANNELS    = 4;
  localparam int DEF_SAMPLE_BITS = 16;

  // Depth of the per-channel sample history (sets the slot counter width)
  localparam int HISTORY_DEPTH = 4;
  localparam int SLOT_BITS     = $clog2(HISTORY_DEPTH);

  // Number of channels carried on the ports
  localparam int PORT_CHANNELS = 4;

  // Configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_STABLE_MASK = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;
  localparam logic [15:0] RST_STABLE_MASK = 16'hFFF0;
  localparam logic [15:0] RST_TIMEOUT     = 16'd1000;

  // Phase numbers as reported on the result beat
  localparam logic [3:0] PH_CLEAR    = 4'd0;
  localparam logic [3:0] PH_RST_UP   = 4'd1;
  localparam logic [3:0] PH_DRIVE_UP = 4'd2;
  localparam logic [3:0] PH_WAIT_UP  = 4'd3;
  localparam logic [3:0] PH_CAPT_UP  = 4'd4;
  localparam logic [3:0] PH_RST_DN   = 4'd5;
  localparam logic [3:0] PH_DRIVE_DN = 4'd6;
  localparam logic [3:0] PH_WAIT_DN  = 4'd7;
  localparam logic [3:0] PH_CAPT_DN  = 4'd8;
  localparam logic [3:0] PH_SORT     = 4'd9;
  localparam logic [3:0] PH_DONE     = 4'd10;

  // Sequencer phases, one-hot
  typedef enum logic [10:0] {
    P_CLEAR    = 11'h001,
    P_RST_UP   = 11'h002,
    P_DRIVE_UP = 11'h004,
    P_WAIT_UP  = 11'h008,
    P_CAPT_UP  = 11'h010,
    P_RST_DN   = 11'h020,
    P_DRIVE_DN = 11'h040,
    P_WAIT_DN  = 11'h080,
    P_CAPT_DN  = 11'h100,
    P_SORT     = 11'h200,
    P_DONE     = 11'h400
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] adc_ch0;
    logic [15:0] adc_ch1;
    logic [15:0] adc_ch2;
    logic [15:0] adc_ch3;
  } item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic        drive_up;
    logic        finished;
    logic        timed_out;
    logic [15:0] min_ch0;
    logic [15:0] max_ch0;
    logic [15:0] min_ch1;
    logic [15:0] max_ch1;
    logic [15:0] min_ch2;
    logic [15:0] max_ch2;
    logic [15:0] min_ch3;
    logic [15:0] max_ch3;
  } result_t;

  // Phase number as reported on the result beat
  function automatic logic [3:0] phase_code(input phase_t p);
    logic [3:0] code;
    unique case (p)
      P_CLEAR:    code = PH_CLEAR;
      P_RST_UP:   code = PH_RST_UP;
      P_DRIVE_UP: code = PH_DRIVE_UP;
      P_WAIT_UP:  code = PH_WAIT_UP;
      P_CAPT_UP:  code = PH_CAPT_UP;
      P_RST_DN:   code = PH_RST_DN;
      P_DRIVE_DN: code = PH_DRIVE_DN;
      P_WAIT_DN:  code = PH_WAIT_DN;
      P_CAPT_DN:  code = PH_CAPT_DN;
      P_SORT:     code = PH_SORT;
      default:    code = PH_DONE;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/four_channel_endstop_calibration_fsm.sv
// Channel  Handshake                  Payload
// item     item_valid / item_stall    item_t   (mode, adc_ch0..adc_ch3)
// result   result_valid / result_stall result_t (phase, flags, min/max per channel)
// config   APB (psel/penable/pwrite)  stable_mask @0x0, timeout_ticks @0x4
//
// One item per cycle unless item_stall is high: an accepted beat updates the
// sequencer state at that edge and its result beat is loaded into the output
// register at the same edge. The output register is the only stage.
// The item side stalls only while the output register is full and stalled.
// rst is synchronous: phase 0, idle (finished), all stores and flags cleared.
module four_channel_endstop_calibration_fsm
  import ecal_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  // Configuration registers
  logic [15:0] stable_mask;
  logic [15:0] timeout_ticks;

  // Sequencer state
  phase_t                phase, phase_next;
  logic                  running, running_next;
  logic [SLOT_BITS-1:0]  slot, slot_next;
  logic [15:0]           wait_ticks, wait_ticks_next;
  logic                  timeout_flag, timeout_flag_next;
  smp_t                  hist [CHANNELS][HISTORY_DEPTH];
  smp_t                  hist_next [CHANNELS][HISTORY_DEPTH];
  smp_t                  capt_a [CHANNELS];
  smp_t                  capt_a_next [CHANNELS];
  smp_t                  capt_b [CHANNELS];
  smp_t                  capt_b_next [CHANNELS];
  smp_t                  lim_min [CHANNELS];
  smp_t                  lim_min_next [CHANNELS];
  smp_t                  lim_max [CHANNELS];
  smp_t                  lim_max_next [CHANNELS];

  logic [15:0] adc_in [PORT_CHANNELS];
  smp_t        smp [CHANNELS];
  logic [15:0] out_min [PORT_CHANNELS];
  logic [15:0] out_max [PORT_CHANNELS];
  logic [15:0] wt_inc;
  logic        stable;
  logic        accept;
  logic        cfg_wr;
  result_t     result_next;

  // APB: always ready, registers decoded on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ticks}
                                            : {16'd0, stable_mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_mask   <= RST_STABLE_MASK;
      timeout_ticks <= RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_STABLE_MASK: stable_mask   <= pwdata[15:0];
        REG_TIMEOUT:     timeout_ticks <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // Handshake: take a beat unless the output register is full and held
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // Sample fan-in; channels past the port width read zero
  assign adc_in[0] = item.adc_ch0;
  assign adc_in[1] = item.adc_ch1;
  assign adc_in[2] = item.adc_ch2;
  assign adc_in[3] = item.adc_ch3;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_smp
    if (c < PORT_CHANNELS) begin : g_port
      assign smp[c] = adc_in[c][SAMPLE_BITS-1:0];
    end else begin : g_zero
      assign smp[c] = '0;
    end
  end

  // Saturating tick counter
  assign wt_inc = (wait_ticks == 16'hFFFF) ? wait_ticks : wait_ticks + 16'd1;

  // Next-state logic for one beat
  always_comb begin
    phase_next        = phase;
    running_next      = running;
    slot_next         = slot;
    wait_ticks_next   = wait_ticks;
    timeout_flag_next = timeout_flag;
    hist_next         = hist;
    capt_a_next       = capt_a;
    capt_b_next       = capt_b;
    lim_min_next      = lim_min;
    lim_max_next      = lim_max;
    stable            = 1'b1;

    // history with this beat's samples written in, and its stability
    for (int c = 0; c < CHANNELS; c++) begin
      hist_next[c][slot] = smp[c];
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
        if ((hist_next[c][k] & stable_mask[SAMPLE_BITS-1:0]) !=
            (hist_next[c][0] & stable_mask[SAMPLE_BITS-1:0])) begin
          stable = 1'b0;
        end
      end
    end
    hist_next = hist;

    if (accept) begin
      priority if (item.mode) begin
        // start: clear everything and run from phase 0
        phase_next        = P_CLEAR;
        running_next      = 1'b1;
        slot_next         = '0;
        wait_ticks_next   = '0;
        timeout_flag_next = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
          for (int k = 0; k < HISTORY_DEPTH; k++) hist_next[c][k] = '0;
          capt_a_next[c]  = '0;
          capt_b_next[c]  = '0;
          lim_min_next[c] = '0;
          lim_max_next[c] = '0;
        end
      end else if (running) begin
        if (phase == P_DONE) begin
          running_next = 1'b0;
        end else if (wt_inc >= timeout_ticks) begin
          wait_ticks_next   = wt_inc;
          timeout_flag_next = 1'b1;
          phase_next        = P_DONE;
        end else begin
          wait_ticks_next = wt_inc;
          unique case (phase)
            P_CLEAR: begin
              for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < HISTORY_DEPTH; k++) hist_next[c][k] = '0;
                lim_min_next[c] = '0;
                lim_max_next[c] = '0;
              end
              phase_next = P_RST_UP;
            end
            P_RST_UP: begin
              wait_ticks_next = '0;
              slot_next       = '0;
              phase_next      = P_DRIVE_UP;
            end
            P_RST_DN: begin
              wait_ticks_next = '0;
              slot_next       = '0;
              phase_next      = P_DRIVE_DN;
            end
            P_DRIVE_UP: phase_next = P_WAIT_UP;
            P_DRIVE_DN: phase_next = P_WAIT_DN;
            P_WAIT_UP, P_WAIT_DN: begin
              for (int c = 0; c < CHANNELS; c++) hist_next[c][slot] = smp[c];
              slot_next = slot + 1'b1;
              if (stable) begin
                phase_next = (phase == P_WAIT_UP) ? P_CAPT_UP : P_CAPT_DN;
              end
            end
            P_CAPT_UP: begin
              capt_a_next = smp;
              phase_next  = P_RST_DN;
            end
            P_CAPT_DN: begin
              capt_b_next = smp;
              phase_next  = P_SORT;
            end
            default: begin
              // sort: order each channel's two captures
              for (int c = 0; c < CHANNELS; c++) begin
                lim_min_next[c] = (capt_a[c] >= capt_b[c]) ? capt_b[c] : capt_a[c];
                lim_max_next[c] = (capt_a[c] >= capt_b[c]) ? capt_a[c] : capt_b[c];
              end
              phase_next = P_DONE;
            end
          endcase
        end
      end else begin
        // tick while idle: state holds
      end
    end
  end

  // Limits on the ports; channels at or past CHANNELS read zero
  for (genvar c = 0; c < PORT_CHANNELS; c++) begin : g_out
    if (c < CHANNELS) begin : g_live
      assign out_min[c] = 16'(lim_min_next[c]);
      assign out_max[c] = 16'(lim_max_next[c]);
    end else begin : g_none
      assign out_min[c] = '0;
      assign out_max[c] = '0;
    end
  end

  // Result beat built from the state after this item
  always_comb begin
    result_next.phase     = phase_code(phase_next);
    result_next.drive_up  = (phase_next == P_WAIT_UP) || (phase_next == P_CAPT_UP) ||
                            (phase_next == P_RST_DN)  || (phase_next == P_DRIVE_DN);
    result_next.finished  = ~running_next;
    result_next.timed_out = timeout_flag_next;
    result_next.min_ch0   = out_min[0];
    result_next.max_ch0   = out_max[0];
    result_next.min_ch1   = out_min[1];
    result_next.max_ch1   = out_max[1];
    result_next.min_ch2   = out_min[2];
    result_next.max_ch2   = out_max[2];
    result_next.min_ch3   = out_min[3];
    result_next.max_ch3   = out_max[3];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_CLEAR;
      running      <= 1'b0;
      slot         <= '0;
      wait_ticks   <= '0;
      timeout_flag <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < HISTORY_DEPTH; k++) hist[c][k] <= '0;
        capt_a[c]  <= '0;
        capt_b[c]  <= '0;
        lim_min[c] <= '0;
        lim_max[c] <= '0;
      end
    end else begin
      phase        <= phase_next;
      running      <= running_next;
      slot         <= slot_next;
      wait_ticks   <= wait_ticks_next;
      timeout_flag <= timeout_flag_next;
      hist         <= hist_next;
      capt_a       <= capt_a_next;
      capt_b       <= capt_b_next;
      lim_min      <= lim_min_next;
      lim_max      <= lim_max_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Idle sequencer sits either before its first step or at done
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !running |-> (phase == P_CLEAR || phase == P_DONE))
    else $error("idle sequencer in a working phase");

  // A timeout always parks the sequencer at done
  a_timeout_done: assert property (@(posedge clk) disable iff (rst)
    timeout_flag |-> phase == P_DONE)
    else $error("timeout flag set outside done phase");

  // Sorted limits of channel 0 stay ordered
  a_limits_order: assert property (@(posedge clk) disable iff (rst)
    lim_min[0] <= lim_max[0])
    else $error("channel 0 minimum above maximum");

  // A result beat is loaded whenever an item is taken
  a_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result beat");
`endif

endmodule
